// ===== src/lfu_sru_pkg.sv =====
// Package for the LFU slot replacement unit: sizes, slot entry type and sequencer states.
package lfu_sru_pkg;

  localparam int SLOT_COUNT = 20;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  // field widths of the request, the result and the register
  localparam int ID_W     = 7;
  localparam int SLOT_W   = 5;
  localparam int USE_W    = 16;
  localparam int STAMP_W  = 32;
  localparam int CFG_W    = 5;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [CFG_W-1:0] SLOTS_RESET = CFG_W'(20);

  // register word address of slots_in_use
  localparam logic [PADDR_W-3:0] REG_SLOTS = '0;

  typedef struct packed {
    logic [ID_W-1:0]    owner;
    logic [USE_W-1:0]   uses;
    logic [STAMP_W-1:0] stamp;
  } slot_ent_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_UPDATE
  } seq_state_t;

endpackage

// ===== src/lfu_slot_replacement_unit.sv =====
// Top level: LFU slot table with oldest-first tie break, scanned one slot per cycle.
//
// Usage:
//   Requests enter on in_valid/in_stall carrying in_candidate_id. Each request
//   returns exactly one result on out_valid/out_stall: hit flag, slot index,
//   evicted flag and id, and the use count after the update.
//   The slot table is a small memory read one slot per cycle. A single compare
//   unit walks slots 0..n-1 (n = active slot count) and tracks the first hit,
//   the first empty slot and the LFU victim at once; the update state then
//   writes the chosen slot and loads the result register. A new request is
//   taken only after the previous one has left the update state. The scan
//   reads one slot at a time through the one memory read port feeding the
//   compare unit.
//   If the receiver stalls, the result holds in the output register; the next
//   request may still be scanned, and its update waits until the old result
//   is taken.
//   Reset (synchronous, rst_n low) empties every slot through per-slot valid
//   bits, clears the request counter and sets slots_in_use to 20. No clearing
//   pass is needed. slots_in_use sits at byte address 0 of the APB port. The
//   user must write it only while no request is in flight; the block does not check.
module lfu_slot_replacement_unit
  import lfu_sru_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [ID_W-1:0]    in_candidate_id,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic [SLOT_W-1:0]  out_slot_index,
  output logic               out_evicted_valid,
  output logic [ID_W-1:0]    out_evicted_id,
  output logic [USE_W-1:0]   out_use_count,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  seq_state_t state_r, state_nxt;

  logic [CFG_W-1:0]   slots_r;
  logic [STAMP_W-1:0] item_cnt_r;

  // request context
  logic [ID_W-1:0]    id_r;
  logic [STAMP_W-1:0] now_r;
  logic [IDX_W-1:0]   last_r;

  // memory and read path
  slot_ent_t          mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] vld_r;
  logic [IDX_W-1:0]   addr_r;
  logic [IDX_W-1:0]   eidx_r;
  logic               eval_r;
  slot_ent_t          rd_ent_r;
  logic               rd_vld_r;
  slot_ent_t          cur;

  // scan trackers
  logic               hit_fnd_r;
  logic [IDX_W-1:0]   hit_idx_r;
  logic [USE_W-1:0]   hit_uses_r;
  logic [STAMP_W-1:0] hit_stamp_r;
  logic               emp_fnd_r;
  logic [IDX_W-1:0]   emp_idx_r;
  logic [IDX_W-1:0]   vic_idx_r;
  slot_ent_t          vic_ent_r;

  // output register
  logic               out_valid_r;
  logic               out_hit_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic               out_ev_vld_r;
  logic [ID_W-1:0]    out_ev_id_r;
  logic [USE_W-1:0]   out_uses_r;

  // control
  logic               accept_in;
  logic               rd_en;
  logic               upd_go;
  logic               last_rd;
  logic [CNT_W-1:0]   n_act;
  logic               cfg_wr;

  // update path
  logic [IDX_W-1:0]   pos;
  logic [USE_W-1:0]   hit_uses_inc;
  slot_ent_t          wr_ent;
  logic               mem_we;
  logic               res_hit;
  logic               res_ev_vld;
  logic [ID_W-1:0]    res_ev_id;
  logic [USE_W-1:0]   res_uses;

  // ---------------------------------------------------------------------
  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_SLOTS);
  assign prdata = (paddr[PADDR_W-1:2] == REG_SLOTS) ? PDATA_W'(slots_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= SLOTS_RESET;
    end else if (cfg_wr) begin
      slots_r <= pwdata[CFG_W-1:0];
    end
  end

  // active slot count, clamped to 1..SLOT_COUNT
  always_comb begin
    if (slots_r == '0) begin
      n_act = CNT_W'(1);
    end else if (32'(slots_r) > SLOT_COUNT) begin
      n_act = CNT_W'(SLOT_COUNT);
    end else begin
      n_act = CNT_W'(slots_r);
    end
  end

  // ---------------------------------------------------------------------
  // sequencer
  assign accept_in = in_valid && !in_stall;
  assign last_rd   = (addr_r == last_r);
  assign upd_go    = (state_r == ST_UPDATE) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept_in) state_nxt = ST_SCAN;
      ST_SCAN:   if (last_rd) state_nxt = ST_LAST;
      ST_LAST:   state_nxt = ST_UPDATE;
      ST_UPDATE: if (upd_go) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_stall = 1'b0;
      ST_SCAN:   rd_en    = 1'b1;
      ST_LAST:   rd_en    = 1'b0;
      ST_UPDATE: rd_en    = 1'b0;
      default:   in_stall = 1'b1;
    endcase
  end

  // request context, read address and eval pipeline
  always_ff @(posedge clk) begin
    if (accept_in) begin
      id_r   <= in_candidate_id;
      now_r  <= item_cnt_r;
      last_r <= IDX_W'(n_act - CNT_W'(1));
    end
    if (accept_in) begin
      addr_r <= '0;
    end else if (rd_en) begin
      addr_r <= addr_r + IDX_W'(1);
    end
    eidx_r <= addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eval_r <= 1'b0;
    end else begin
      eval_r <= rd_en;
    end
  end

  // request counter, saturating
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_cnt_r <= '0;
    end else if (accept_in && (item_cnt_r != '1)) begin
      item_cnt_r <= item_cnt_r + STAMP_W'(1);
    end
  end

  // ---------------------------------------------------------------------
  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pos] <= wr_ent;
    end
    if (rd_en) begin
      rd_ent_r <= mem[addr_r];
      rd_vld_r <= vld_r[addr_r];
    end
  end

  // a slot never written reads as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[pos] <= 1'b1;
    end
  end

  assign cur = rd_vld_r ? rd_ent_r : '0;

  // ---------------------------------------------------------------------
  // shared compare unit: first hit, first empty, LFU victim
  always_ff @(posedge clk) begin
    if (accept_in) begin
      hit_fnd_r <= 1'b0;
      emp_fnd_r <= 1'b0;
    end else if (eval_r) begin
      if (!hit_fnd_r && (cur.owner == id_r)) begin
        hit_fnd_r   <= 1'b1;
        hit_idx_r   <= eidx_r;
        hit_uses_r  <= cur.uses;
        hit_stamp_r <= cur.stamp;
      end
      if (!emp_fnd_r && (cur.owner == '0)) begin
        emp_fnd_r <= 1'b1;
        emp_idx_r <= eidx_r;
      end
      // smaller count wins, then older stamp; ties keep the lower slot
      if ((eidx_r == '0) || (cur.uses < vic_ent_r.uses) ||
          ((cur.uses == vic_ent_r.uses) && (cur.stamp < vic_ent_r.stamp))) begin
        vic_idx_r <= eidx_r;
        vic_ent_r <= cur;
      end
    end
  end

  // ---------------------------------------------------------------------
  // update: pick the slot, write it, form the result
  assign hit_uses_inc = (hit_uses_r == '1) ? hit_uses_r : hit_uses_r + USE_W'(1);

  always_comb begin
    pos        = vic_idx_r;
    res_hit    = 1'b0;
    res_ev_vld = 1'b0;
    res_ev_id  = '0;
    res_uses   = USE_W'(1);
    wr_ent     = '{owner: id_r, uses: USE_W'(1), stamp: now_r};
    if (id_r == '0) begin
      // reserved id: no slot touched, all-zero result
      pos      = '0;
      res_uses = '0;
    end else if (hit_fnd_r) begin
      pos      = hit_idx_r;
      res_hit  = 1'b1;
      res_uses = hit_uses_inc;
      wr_ent   = '{owner: id_r, uses: hit_uses_inc, stamp: hit_stamp_r};
    end else if (emp_fnd_r) begin
      pos = emp_idx_r;
    end else begin
      res_ev_vld = 1'b1;
      res_ev_id  = vic_ent_r.owner;
    end
  end

  assign mem_we = upd_go && (id_r != '0);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_go) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      out_hit_r    <= res_hit;
      out_slot_r   <= SLOT_W'(pos);
      out_ev_vld_r <= res_ev_vld;
      out_ev_id_r  <= res_ev_id;
      out_uses_r   <= res_uses;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_slot_index    = out_slot_r;
  assign out_evicted_valid = out_ev_vld_r;
  assign out_evicted_id    = out_ev_id_r;
  assign out_use_count     = out_uses_r;

endmodule
